/* rtl/iirl_pkg.sv */
// Shared types, operation codes and size defaults for the indexed insert/remove list.
package iirl_pkg;

    // Request operation codes
    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    // Field widths of the request and result items
    localparam int MODE_W  = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 5;

    // Default sizes
    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_ITEM_WIDTH = 32;

    // Index width wide enough for any supported depth (up to 256, plus the count itself)
    localparam int IDX_W = 9;

    // Shift control broadcast to every cell of the row
    typedef struct packed {
        logic             ins;  // open a gap at pos and store the new item there
        logic             rem;  // close the gap at pos, cells above move down
        logic [IDX_W-1:0] pos;  // effective position of the operation
    } iirl_ctl_t;

endpackage

/* rtl/indexed_insert_remove_list_top.sv */
// Top level of the indexed insert/remove list: request decode, cell row and result register.
//
// Usage:
//   Requests enter on the s_ channel (s_mode, s_position, s_item_value) with
//   s_valid/s_ready; one result per request leaves on the m_ channel
//   (m_success, m_taken_item, m_length_now) with m_valid/m_ready.
//   Modes: push, pop, insert at position, remove at position.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while results are taken at once; every
//   cell of the row moves in parallel in that same cycle, and the taken item
//   comes from a select across the row into the result register.
//   Stall: while a result waits unaccepted and m_ready is low, s_ready is low; a new request is
//   taken in the same cycle that the waiting result is taken.
//   Reset (aresetn low, synchronous): the list becomes empty and no result is
//   pending. Entry contents are not cleared; only entries below the length are
//   ever read, so no clearing pass is needed.
//   A failed request (empty, full or bad position) leaves the list unchanged
//   and returns success low with a zero item.
module indexed_insert_remove_list_top #(
    parameter int DEPTH      = iirl_pkg::DEFAULT_DEPTH,
    parameter int ITEM_WIDTH = iirl_pkg::DEFAULT_ITEM_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [iirl_pkg::MODE_W-1:0]   s_mode,
    input  logic [iirl_pkg::POS_W-1:0]    s_position,
    input  logic [iirl_pkg::VALUE_W-1:0]  s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_success,
    output logic [iirl_pkg::VALUE_W-1:0]  m_taken_item,
    output logic [iirl_pkg::LEN_W-1:0]    m_length_now
);
    import iirl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SEL_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  m_valid_reg;
    logic                  m_success_reg;
    logic [VALUE_W-1:0]    m_taken_item_reg;
    logic [LEN_W-1:0]      m_length_now_reg;

    logic                  fire;
    logic [IDX_W-1:0]      cnt_w;
    logic [IDX_W-1:0]      eff_pos;
    logic                  is_ins;
    logic                  ins_ok;
    logic                  rem_ok;
    logic [ITEM_WIDTH-1:0] item;
    logic [ITEM_WIDTH-1:0] taken;
    iirl_ctl_t             ctl;
    logic [ITEM_WIDTH-1:0] cell_data [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;
    assign cnt_w   = IDX_W'(cnt_reg);
    assign item    = ITEM_WIDTH'(s_item_value);

    // Map push and pop onto insert and remove at the tail
    always_comb begin
        case (s_mode)
            MODE_PUSH: begin
                is_ins  = 1'b1;
                eff_pos = cnt_w;
            end
            MODE_POP: begin
                is_ins  = 1'b0;
                eff_pos = (cnt_reg == '0) ? '0 : cnt_w - IDX_W'(1);
            end
            MODE_INSERT: begin
                is_ins  = 1'b1;
                eff_pos = IDX_W'(s_position);
            end
            default: begin
                is_ins  = 1'b0;
                eff_pos = IDX_W'(s_position);
            end
        endcase
    end

    // Bounds checks
    assign ins_ok = is_ins && (eff_pos <= cnt_w) && (cnt_w < DEPTH_IDX);
    assign rem_ok = !is_ins && (eff_pos < cnt_w);

    // Shift control for the row
    assign ctl.ins = fire && ins_ok;
    assign ctl.rem = fire && rem_ok;
    assign ctl.pos = eff_pos;

    // Row of cells, each linked to its neighbours
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ITEM_WIDTH-1:0] lower_data;
        logic [ITEM_WIDTH-1:0] upper_data;
        if (i == 0) begin : g_first
            assign lower_data = item;
        end else begin : g_mid_lo
            assign lower_data = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign upper_data = cell_data[i];
        end else begin : g_mid_hi
            assign upper_data = cell_data[i+1];
        end
        iirl_cell #(
            .IDX        (i),
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .item       (item),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .data       (cell_data[i])
        );
    end

    // Item leaving the list; position is below the length when used
    assign taken = rem_ok ? cell_data[eff_pos[SEL_W-1:0]] : '0;

    // Length update
    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.ins) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (ctl.rem) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_success_reg    <= ins_ok || rem_ok;
            m_taken_item_reg <= VALUE_W'(taken);
            m_length_now_reg <= LEN_W'(cnt_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_success    = m_success_reg;
    assign m_taken_item = m_taken_item_reg;
    assign m_length_now = m_length_now_reg;

    // Length never exceeds capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("list length beyond capacity");

    // A successful removal shortens the list by one
    a_rem_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rem |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("removal did not shorten the list");

    // Failed requests return no item
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_success_reg) |-> m_taken_item_reg == '0)
        else $error("failed request returned an item");

    // A pending result reports the current length
    a_len_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_length_now_reg == LEN_W'(cnt_reg))
        else $error("reported length differs from stored length");

endmodule

/* rtl/iirl_cell.sv */
// One storage cell of the list: holds one entry and shifts with its neighbours.
module iirl_cell #(
    parameter int IDX        = 0,
    parameter int ITEM_WIDTH = iirl_pkg::DEFAULT_ITEM_WIDTH
) (
    input  logic                      aclk,
    input  iirl_pkg::iirl_ctl_t       ctl,
    input  logic [ITEM_WIDTH-1:0]     item,
    input  logic [ITEM_WIDTH-1:0]     lower_data,
    input  logic [ITEM_WIDTH-1:0]     upper_data,
    output logic [ITEM_WIDTH-1:0]     data
);
    import iirl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [ITEM_WIDTH-1:0] data_reg;
    logic [ITEM_WIDTH-1:0] data_next;

    // Select: hold, take from the lower neighbour, take the new item or the upper neighbour
    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (MY_IDX > ctl.pos) begin
                data_next = lower_data;
            end else if (MY_IDX == ctl.pos) begin
                data_next = item;
            end
        end else if (ctl.rem) begin
            if (MY_IDX >= ctl.pos) begin
                data_next = upper_data;
            end
        end
    end

    // Entry storage, undefined until written
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* verif/indexed_insert_remove_list_top_tb.sv */
// Self-checking testbench for the indexed insert/remove list: directed table, then random traffic.
`timescale 1ns / 1ps

module indexed_insert_remove_list_top_tb;
    import iirl_pkg::*;

    localparam int LIST_DEPTH   = DEFAULT_DEPTH;
    localparam int DIR_ROWS     = 22;
    localparam int RANDOM_ITEMS = 630;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    // One result item as the list answers it
    typedef struct packed {
        logic               success;
        logic [VALUE_W-1:0] taken;
        logic [LEN_W-1:0]   len_now;
    } list_result_t;

    // One row of the directed table; typed rows carry their answer
    typedef struct packed {
        logic [MODE_W-1:0]  op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic [7:0]         reps;
        logic               typed;
        list_result_t       want;
    } dir_row_t;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_style_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [MODE_W-1:0]  s_mode       = MODE_PUSH;
    logic [POS_W-1:0]   s_position   = '0;
    logic [VALUE_W-1:0] s_item_value = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_success;
    logic [VALUE_W-1:0] m_taken_item;
    logic [LEN_W-1:0]   m_length_now;

    // Shadow copy of the list
    logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
    int unsigned        shadow_count = 0;

    list_result_t expected_results [$];
    dir_row_t     dir_table [DIR_ROWS];

    idle_style_t tx_style      = IDLE_FULL;
    bit          rx_holding    = 1'b0;
    int          error_count   = 0;
    int          accepted      = 0;
    int          results_seen  = 0;
    int          ok_count      = 0;
    int          refused_count = 0;
    int          full_hits     = 0;
    int          empty_hits    = 0;

    indexed_insert_remove_list_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_success    (m_success),
        .m_taken_item (m_taken_item),
        .m_length_now (m_length_now)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the shadow list and return its answer
    function automatic list_result_t list_apply(input logic [MODE_W-1:0] op,
                                                input logic [POS_W-1:0] pos_in,
                                                input logic [VALUE_W-1:0] value);
        list_result_t r;
        int unsigned  p;
        bit           grows;
        r     = '0;
        p     = pos_in;
        grows = (op == MODE_PUSH) || (op == MODE_INSERT);
        if (op == MODE_PUSH)
            p = shadow_count;
        else if (op == MODE_POP)
            p = (shadow_count == 0) ? 0 : shadow_count - 1;
        if (grows) begin
            if (p <= shadow_count && shadow_count < LIST_DEPTH) begin
                for (int i = shadow_count; i > p; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[p] = value;
                shadow_count++;
                r.success = 1'b1;
            end
        end else begin
            if (p < shadow_count) begin
                r.taken = shadow_entries[p];
                for (int i = p; i + 1 < shadow_count; i++)
                    shadow_entries[i] = shadow_entries[i+1];
                shadow_count--;
                r.success = 1'b1;
            end
        end
        r.len_now = shadow_count[LEN_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap(input idle_style_t style);
        case (style)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(19, 0);
            default:   return ($urandom_range(3, 0) == 0) ? $urandom_range(19, 0) : 0;
        endcase
    endfunction

    // Offer one request item, wait for it to be taken, then log what should come back
    task automatic offer_request(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [VALUE_W-1:0] value, input bit typed,
                                 input list_result_t want);
        int           gap;
        list_result_t calc;
        gap = rx_holding ? 0 : draw_gap(tx_style);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= op;
        s_position   <= pos;
        s_item_value <= value;
        do @(posedge aclk); while (!s_ready);
        calc = list_apply(op, pos, value);
        expected_results.push_back(typed ? want : calc);
        accepted++;
        if (calc.success) begin
            ok_count++;
            if (calc.len_now == LIST_DEPTH) full_hits++;
            if (calc.len_now == 0) empty_hits++;
        end else begin
            refused_count++;
        end
    endtask

    // Directed table
    initial begin
        dir_table[0]  = '{MODE_POP,    5'd0,  32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}};
        dir_table[1]  = '{MODE_REMOVE, 5'd0,  32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}};
        dir_table[2]  = '{MODE_INSERT, 5'd1,  32'h1111_1111, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}};
        dir_table[3]  = '{MODE_INSERT, 5'd0,  32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd1}};
        dir_table[4]  = '{MODE_PUSH,   5'd31, 32'h0000_0000, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd2}};
        dir_table[5]  = '{MODE_INSERT, 5'd1,  32'hA5A5_A5A5, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd3}};
        dir_table[6]  = '{MODE_REMOVE, 5'd31, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd3}};
        dir_table[7]  = '{MODE_INSERT, 5'd31, 32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd3}};
        dir_table[8]  = '{MODE_REMOVE, 5'd3,  32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd3}};
        dir_table[9]  = '{MODE_INSERT, 5'd4,  32'h2222_2222, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd3}};
        dir_table[10] = '{MODE_REMOVE, 5'd1,  32'h0000_0000, 8'd1,  1'b1,
                          '{1'b1, 32'hA5A5_A5A5, 5'd2}};
        dir_table[11] = '{MODE_POP,    5'd17, 32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd1}};
        // insert at the length behaves as a push
        dir_table[12] = '{MODE_INSERT, 5'd1,  32'h1234_5678, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd2}};
        dir_table[13] = '{MODE_PUSH,   5'd0,  32'h0000_0000, 8'd14, 1'b0, '0};
        // list now full
        dir_table[14] = '{MODE_PUSH,   5'd0,  32'h3333_3333, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd16}};
        dir_table[15] = '{MODE_INSERT, 5'd0,  32'h4444_4444, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd16}};
        dir_table[16] = '{MODE_INSERT, 5'd16, 32'h5555_5555, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd16}};
        dir_table[17] = '{MODE_REMOVE, 5'd16, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd16}};
        dir_table[18] = '{MODE_REMOVE, 5'd15, 32'h0000_0000, 8'd1,  1'b0, '0};
        dir_table[19] = '{MODE_INSERT, 5'd7,  32'h5A5A_5A5A, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd16}};
        dir_table[20] = '{MODE_REMOVE, 5'd0,  32'h0000_0000, 8'd1,  1'b1,
                          '{1'b1, 32'hFFFF_FFFF, 5'd15}};
        dir_table[21] = '{MODE_POP,    5'd0,  32'h0000_0000, 8'd16, 1'b0, '0};
    end

    // Request side: reset, directed rows, random traffic, then drain
    initial begin
        logic [MODE_W-1:0]  op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        int                 bias;
        int                 w;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[r]) begin
            for (int k = 0; k < dir_table[r].reps; k++) begin
                value = (dir_table[r].reps > 1) ? $urandom : dir_table[r].value;
                offer_request(dir_table[r].op, dir_table[r].pos, value,
                              dir_table[r].typed, dir_table[r].want);
            end
        end

        // Random part: phases alternate between growing and shrinking the list
        bias = 75;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) tx_style = idle_style_t'($urandom_range(2, 0));
            if (n % 40 == 0) bias = ((n / 40) % 2 == 0) ? 80 : 20;
            case ($urandom_range(7, 0))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom;
            endcase
            if ($urandom_range(99, 0) < 15) begin
                // noise: any mode, any position the field allows
                op  = MODE_W'($urandom_range(3, 0));
                pos = POS_W'($urandom_range(31, 0));
            end else if ($urandom_range(99, 0) < bias) begin
                op  = $urandom_range(1, 0) ? MODE_INSERT : MODE_PUSH;
                pos = POS_W'($urandom_range(shadow_count, 0));
            end else begin
                op  = $urandom_range(1, 0) ? MODE_REMOVE : MODE_POP;
                pos = (shadow_count == 0) ? '0 : POS_W'($urandom_range(shadow_count - 1, 0));
            end
            offer_request(op, pos, value, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Let outstanding results arrive
        for (w = 0; w < 1000 && expected_results.size() != 0; w++) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end

        $display("Covered %0d requests (%0d done, %0d refused), %0d results compared",
                 accepted, ok_count, refused_count, results_seen);
        $display("List filled to capacity %0d times and emptied %0d times",
                 full_hits, empty_hits);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off
    initial begin
        idle_style_t rx_style;
        int          gap;
        int          rx_count;
        bit          hold_done;
        rx_style  = IDLE_FULL;
        rx_count  = 0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            if (rx_count % 50 == 0) rx_style = idle_style_t'($urandom_range(2, 0));
            gap = draw_gap(rx_style);
            if (!hold_done && rx_count >= 300) begin
                hold_done  = 1'b1;
                rx_holding = 1'b1;
                gap        = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            rx_holding = 1'b0;
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_count++;
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin : result_compare
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with no request outstanding");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                if (m_success !== want.success) begin
                    $error("success: expected %0b, got %0b", want.success, m_success);
                    error_count++;
                end
                if (m_taken_item !== want.taken) begin
                    $error("taken_item: expected %h, got %h", want.taken, m_taken_item);
                    error_count++;
                end
                if (m_length_now !== want.len_now) begin
                    $error("length_now: expected %0d, got %0d", want.len_now, m_length_now);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
